>>> sv/thsf_pkg.sv
// Package with the types, constants and command struct of the treble high-shelf filter.
package thsf_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int LP_BITS      = 32;
	localparam int EXT_BITS     = LP_BITS - SAMPLE_BITS;
	localparam int CH_BITS      = 5;
	localparam int BOOST_BITS   = 19;
	localparam int POLE_BITS    = 16;
	localparam int RAMP_BITS    = 17;
	localparam int CHANS_BITS   = 6;
	localparam int CNT_BITS     = 7;
	localparam int MAX_CHAN_DEF = 32;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 19;

	localparam logic [CFG_IDX_BITS-1:0] REG_POLE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAMP   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANS  = 3'd3;

	localparam logic [POLE_BITS-1:0]         POLE_RESET   = 16'd38824;
	localparam logic [RAMP_BITS-1:0]         RAMP_RESET   = 17'd27;
	localparam logic signed [BOOST_BITS-1:0] TARGET_RESET = 19'sd0;
	localparam logic [CHANS_BITS-1:0]        CHANS_RESET  = 6'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [CH_BITS-1:0]            channel;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [CH_BITS-1:0]            channel_out;
		logic                          clipped;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic ramp;
		logic lp;
		logic hp;
		logic mul;
		logic load;
	} cmd_t;

endpackage

>>> sv/thsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module thsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/thsf_ctrl.sv
// Sequencing state machine and output handshake of the treble high-shelf filter.
module thsf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	output logic          dst_valid,
	input  logic          dst_stall,
	output thsf_pkg::cmd_t cmd
);
	import thsf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RAMP = 3'd1;
	localparam logic [2:0] ST_LP   = 3'd2;
	localparam logic [2:0] ST_HP   = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || !dst_stall;
	assign src_stall = !((state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free));
	assign accept    = src_valid && !src_stall;
	assign dst_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		cmd.ramp   = (state_q == ST_RAMP);
		cmd.lp     = (state_q == ST_LP);
		cmd.hp     = (state_q == ST_HP);
		cmd.mul    = (state_q == ST_MUL);
		cmd.load   = (state_q == ST_FIN) && out_free;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_RAMP;
				end
			end
			ST_RAMP: state_nx = ST_LP;
			ST_LP:   state_nx = ST_HP;
			ST_HP:   state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_nx = accept ? ST_RAMP : ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RAMP)
		else $error("Accepted transfer did not start the sequence.");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("Loaded result was not presented.");

	a_blocked_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_valid_q && dst_stall |-> src_stall)
		else $error("Input taken while the finished result could not leave.");

endmodule

>>> sv/thsf_dp.sv
// Datapath of the treble high-shelf filter: registers, boost ramp, lowpass and shelf math.
module thsf_dp #(
	parameter int MAX_CHAN = thsf_pkg::MAX_CHAN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  thsf_pkg::cmd_t                      cmd,
	input  thsf_pkg::in_item_t                  src_data,
	output thsf_pkg::out_item_t                 dst_data,
	input  logic                                cfg_wr_en,
	input  logic [thsf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [thsf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import thsf_pkg::*;

	localparam int CH_AW = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
	localparam int PR_W  = RAMP_BITS + 1 + BOOST_BITS + 1;
	localparam int PL_W  = POLE_BITS + 1 + LP_BITS + 1;
	localparam int PO_W  = BOOST_BITS + LP_BITS + 1;
	localparam int TOT_W = PO_W + 1;

	localparam logic signed [BOOST_BITS-1:0] BOOST_MIN = -19'sd65536;
	localparam logic [RAMP_BITS-1:0]         RAMP_MAX  = 17'd65536;
	localparam logic signed [TOT_W-1:0] YMAX = (TOT_W'(1) <<< (SAMPLE_BITS - 1)) - TOT_W'(1);
	localparam logic signed [TOT_W-1:0] YMIN = -(TOT_W'(1) <<< (SAMPLE_BITS - 1));
	localparam logic signed [TOT_W-1:0] Y_RND = TOT_W'(1) <<< (15 + EXT_BITS);

	logic [POLE_BITS-1:0]         pole_q;
	logic [RAMP_BITS-1:0]         ramp_q;
	logic signed [BOOST_BITS-1:0] target_q;
	logic [CHANS_BITS-1:0]        chans_q;
	logic signed [BOOST_BITS-1:0] boost_q;
	logic [MAX_CHAN-1:0]          valid_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [CH_BITS-1:0]            ch_q;
	logic                          use_q;
	logic signed [PR_W-1:0]        prod_r_q;
	logic signed [BOOST_BITS:0]    d_q;
	logic signed [LP_BITS:0]       diff_q;
	logic signed [PL_W-1:0]        prod_lp_q;
	logic signed [LP_BITS:0]       hp_q;
	logic signed [PO_W-1:0]        prod_out_q;

	logic [CNT_BITS-1:0]           count;
	logic [CH_AW-1:0]              ch_idx_q;
	logic [LP_BITS-1:0]            ram_rd;
	logic signed [LP_BITS-1:0]     xs;
	logic signed [LP_BITS-1:0]     lp_old;
	logic signed [LP_BITS:0]       diff;
	logic signed [BOOST_BITS-1:0]  target_c;
	logic [RAMP_BITS-1:0]          ramp_c;
	logic signed [BOOST_BITS:0]    d;
	logic signed [PR_W-1:0]        prod_r;
	logic signed [PR_W-1:0]        step_w;
	logic signed [BOOST_BITS-1:0]  step;
	logic signed [BOOST_BITS-1:0]  boost_nx;
	logic signed [PL_W-1:0]        prod_lp;
	logic signed [PL_W-1:0]        lp_sh;
	logic signed [LP_BITS-1:0]     lp_new;
	logic signed [LP_BITS:0]       hp;
	logic signed [PO_W-1:0]        prod_out;
	logic signed [TOT_W-1:0]       y_w;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          clip;

	always_comb begin
		count = {1'b0, chans_q};
		if (chans_q == '0) begin
			count = CNT_BITS'(1);
		end else if ({1'b0, chans_q} > CNT_BITS'(MAX_CHAN)) begin
			count = CNT_BITS'(MAX_CHAN);
		end
	end

	assign ch_idx_q = CH_AW'(ch_q);
	assign xs       = LP_BITS'(x_q) <<< EXT_BITS;

	thsf_ram #(
		.WIDTH(LP_BITS),
		.DEPTH(MAX_CHAN)
	) u_lp_ram (
		.clk  (clk),
		.we   (cmd.hp && use_q),
		.waddr(ch_idx_q),
		.wdata(lp_new),
		.re   (cmd.accept),
		.raddr(CH_AW'(src_data.channel)),
		.rdata(ram_rd)
	);

	assign lp_old   = valid_q[ch_idx_q] ? signed'(ram_rd) : '0;
	assign diff     = (LP_BITS + 1)'(lp_old) - (LP_BITS + 1)'(xs);
	assign target_c = (target_q < BOOST_MIN) ? BOOST_MIN : target_q;
	assign ramp_c   = (ramp_q > RAMP_MAX) ? RAMP_MAX : ramp_q;
	assign d        = (BOOST_BITS + 1)'(target_c) - (BOOST_BITS + 1)'(boost_q);
	assign prod_r   = signed'({1'b0, ramp_c}) * d;

	// Truncate the ramp product toward zero, then force a minimum step of one LSB.
	assign step_w   = (prod_r_q + (prod_r_q[PR_W-1] ? PR_W'(65535) : PR_W'(0))) >>> 16;
	assign step     = (step_w == '0 && d_q != '0) ? (d_q[BOOST_BITS] ? -19'sd1 : 19'sd1)
		: signed'(step_w[BOOST_BITS-1:0]);
	assign boost_nx = boost_q + step;

	assign prod_lp  = signed'({1'b0, pole_q}) * diff_q;
	assign lp_sh    = (prod_lp_q + PL_W'(32768)) >>> 16;
	assign lp_new   = xs + signed'(lp_sh[LP_BITS-1:0]);
	assign hp       = (LP_BITS + 1)'(xs) - (LP_BITS + 1)'(lp_new);
	assign prod_out = boost_q * hp_q;

	assign y_w = ((TOT_W'(xs) <<< 16) + TOT_W'(prod_out_q) + Y_RND) >>> (16 + EXT_BITS);

	always_comb begin
		clip  = 1'b0;
		y_sat = SAMPLE_BITS'(y_w);
		if (y_w > YMAX) begin
			y_sat = SAMPLE_BITS'(YMAX);
			clip  = 1'b1;
		end else if (y_w < YMIN) begin
			y_sat = SAMPLE_BITS'(YMIN);
			clip  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q   <= POLE_RESET;
			ramp_q   <= RAMP_RESET;
			target_q <= TARGET_RESET;
			chans_q  <= CHANS_RESET;
			boost_q  <= '0;
			valid_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_POLE:   pole_q   <= cfg_wdata[POLE_BITS-1:0];
					REG_RAMP:   ramp_q   <= cfg_wdata[RAMP_BITS-1:0];
					REG_TARGET: target_q <= signed'(cfg_wdata[BOOST_BITS-1:0]);
					REG_CHANS:  chans_q  <= cfg_wdata[CHANS_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.lp && ch_q == '0) begin
				boost_q <= boost_nx;
			end
			if (cmd.hp && use_q) begin
				valid_q[ch_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= src_data.sample_in;
			ch_q  <= src_data.channel;
			use_q <= CNT_BITS'(src_data.channel) < count;
		end
		if (cmd.ramp) begin
			prod_r_q <= prod_r;
			d_q      <= d;
			diff_q   <= diff;
		end
		if (cmd.lp) begin
			prod_lp_q <= prod_lp;
		end
		if (cmd.hp) begin
			hp_q <= hp;
		end
		if (cmd.mul) begin
			prod_out_q <= prod_out;
		end
		if (cmd.load) begin
			dst_data.sample_out  <= use_q ? y_sat : x_q;
			dst_data.channel_out <= ch_q;
			dst_data.clipped     <= use_q && clip;
		end
	end

	a_boost_only_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lp && ch_q != '0 |=> $stable(boost_q))
		else $error("Boost moved on a sample that does not start a frame.");

	a_unused_passes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !use_q |=> dst_data.sample_out == $past(x_q) && !dst_data.clipped)
		else $error("Sample of an unused channel was not passed through.");

	a_boost_floor: assert property (@(posedge clk) disable iff (!arst_n)
		boost_q >= BOOST_MIN)
		else $error("Boost fell below minus one.");

endmodule

>>> sv/treble_high_shelf_filter.sv
// Top level of the treble high-shelf filter: controller, datapath and lowpass state RAM.
//
//   Channel   Direction  Signals                        Content
//   src       in         src_valid, src_stall, src_data  sample_in, channel
//   dst       out        dst_valid, dst_stall, dst_data  sample_out, channel_out, clipped
//   cfg       in         cfg_wr_en, cfg_index, cfg_wdata register writes, no read-back
//
// A sample passes five steps from transfer to result load, each step in a state of its own: the
// ramp multiply on the channel state read at the transfer, the lowpass multiply, the lowpass
// update with the highpass difference, the shelf multiply, and the output register load.
// The next sample is taken in the cycle its predecessor's result is loaded, so the block takes
// no new sample while an earlier one is still in its steps.
// Reset clears the boost and per-channel valid bits at once; no clearing pass is run.
// A stalled result holds the sequence in its last step until the output register frees.
module treble_high_shelf_filter #(
	parameter int MAX_CHAN = thsf_pkg::MAX_CHAN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  thsf_pkg::in_item_t                  src_data,
	output logic                                dst_valid,
	input  logic                                dst_stall,
	output thsf_pkg::out_item_t                 dst_data,
	input  logic                                cfg_wr_en,
	input  logic [thsf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [thsf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import thsf_pkg::*;

	cmd_t cmd;

	thsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.cmd      (cmd)
	);

	thsf_dp #(
		.MAX_CHAN(MAX_CHAN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.src_data (src_data),
		.dst_data (dst_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

endmodule
